// ===== rtl/wirt_pkg.sv =====
package wirt_pkg;

    // Number of tracked sequence numbers; slot and count widths follow from it.
    localparam int WINDOW = 32;
    localparam int SLOT_W = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);

    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_DONE     = 2'd1,
        OP_REASSIGN = 2'd2,
        OP_UNUSED   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_ASSIGNED   = 3'd0,
        ST_REASSIGNED = 3'd1,
        ST_NONE       = 3'd2,
        ST_RELEASED   = 3'd3,
        ST_DUPLICATE  = 3'd4,
        ST_UNKNOWN    = 3'd5,
        ST_FULL       = 3'd6,
        ST_HELD       = 3'd7
    } status_t;

    typedef enum logic {
        BK_IDLE,
        BK_RELEASE
    } bk_state_t;

    // One command word passed from the front end to the back end.
    typedef struct packed {
        op_t         op;
        logic [31:0] seq;
        logic [31:0] tag;
    } cmd_t;

    // Slot arithmetic modulo the window size.
    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
                                                   input logic [SLOT_W-1:0] b);
        logic [SLOT_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (SLOT_W+1)'(WINDOW)) begin
            sum = sum - (SLOT_W+1)'(WINDOW);
        end
        return sum[SLOT_W-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] slot_sub(input logic [SLOT_W-1:0] a,
                                                   input logic [SLOT_W-1:0] b);
        logic [SLOT_W:0] dif;
        if (a >= b) begin
            dif = {1'b0, a} - {1'b0, b};
        end else begin
            dif = {1'b0, a} + (SLOT_W+1)'(WINDOW) - {1'b0, b};
        end
        return dif[SLOT_W-1:0];
    endfunction

endpackage

// ===== rtl/wirt_front.sv =====
module wirt_front import wirt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [31:0] s_seq,
    input  logic [31:0] s_item_tag,
    output logic        cmd_valid,
    input  logic        cmd_ready,
    output cmd_t        cmd
);

    cmd_t        fifo_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push, pop;

    // Accept while the two-word queue has room; unused opcodes are dropped here.
    assign s_ready   = (count_reg != 2'd2);
    assign push      = s_valid && s_ready && (op_t'(s_op) != OP_UNUSED);
    assign cmd_valid = (count_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = fifo_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= '{op: op_t'(s_op), seq: s_seq, tag: s_item_tag};
        end
    end

endmodule

// ===== rtl/wirt_back.sv =====
module wirt_back import wirt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  cmd_t        cmd,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [31:0] m_out_seq,
    output logic [31:0] m_out_tag,
    output logic        m_last,
    output logic [31:0] m_done_count
);

    bk_state_t          state_reg, state_next;
    logic [31:0]        next_seq_reg, next_seq_next;
    logic [31:0]        oldest_reg, oldest_next;
    logic [SLOT_W-1:0]  oslot_reg, oslot_next;
    logic [31:0]        compl_reg, compl_next;
    logic [WINDOW-1:0]  ip_reg, ip_next;
    logic [WINDOW-1:0]  held_reg, held_next;
    logic [31:0]        tag_reg [WINDOW];
    logic [SLOT_W-1:0]  nlink_reg [WINDOW];
    logic [SLOT_W-1:0]  nlink_next [WINDOW];
    logic [SLOT_W-1:0]  plink_reg [WINDOW];
    logic [SLOT_W-1:0]  plink_next [WINDOW];
    logic [SLOT_W-1:0]  head_reg, head_next;
    logic [SLOT_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]   qcnt_reg, qcnt_next;
    logic [CNT_W-1:0]   k_reg, k_next;

    logic               m_valid_reg, m_valid_next;
    status_t            m_status_reg, m_status_next;
    logic [31:0]        m_seq_reg, m_seq_next;
    logic [31:0]        m_tag_reg, m_tag_next;
    logic               m_last_reg, m_last_next;
    logic [31:0]        m_cnt_reg, m_cnt_next;

    logic               out_free, exec, step;
    logic               tag_we;
    logic [SLOT_W-1:0]  tag_addr;
    logic [31:0]        outstanding, seq_dist, back_dist;
    logic [SLOT_W-1:0]  s_slot, h_slot, n_slot, p_slot, nx_slot;
    logic               more;

    assign out_free  = !m_valid_reg || m_ready;
    assign exec      = (state_reg == BK_IDLE) && cmd_valid && out_free;
    assign step      = (state_reg == BK_RELEASE) && out_free;
    assign cmd_ready = exec;

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_out_seq    = m_seq_reg;
    assign m_out_tag    = m_tag_reg;
    assign m_last       = m_last_reg;
    assign m_done_count = m_cnt_reg;

    // Window position of the incoming command.
    assign outstanding = next_seq_reg - oldest_reg;
    assign seq_dist    = cmd.seq - oldest_reg;
    assign back_dist   = oldest_reg - cmd.seq;
    assign h_slot      = head_reg;
    assign nx_slot     = slot_add(oslot_reg, SLOT_W'(1));
    assign more        = (oldest_reg + 32'd1 != next_seq_reg) &&
                         held_reg[nx_slot] &&
                         ({1'b0, k_reg} + (CNT_W+1)'(1) < (CNT_W+1)'(WINDOW));

    always_comb begin
        if (cmd.op == OP_ADD) begin
            s_slot = slot_add(oslot_reg, outstanding[SLOT_W-1:0]);
        end else if (cmd.op == OP_REASSIGN) begin
            s_slot = h_slot;
        end else begin
            s_slot = slot_add(oslot_reg, seq_dist[SLOT_W-1:0]);
        end
        n_slot = nlink_reg[s_slot];
        p_slot = plink_reg[s_slot];
    end

    // Next state of the release sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (exec && cmd.op == OP_DONE && seq_dist < outstanding &&
                    !held_reg[s_slot] && ip_reg[s_slot] && seq_dist == 32'd0) begin
                    state_next = BK_RELEASE;
                end
            end
            BK_RELEASE: begin
                if (step && !more) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Command execution, release steps and the result register.
    always_comb begin
        next_seq_next = next_seq_reg;
        oldest_next   = oldest_reg;
        oslot_next    = oslot_reg;
        compl_next    = compl_reg;
        ip_next       = ip_reg;
        held_next     = held_reg;
        nlink_next    = nlink_reg;
        plink_next    = plink_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        qcnt_next     = qcnt_reg;
        k_next        = k_reg;
        tag_we        = 1'b0;
        tag_addr      = s_slot;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_seq_next    = m_seq_reg;
        m_tag_next    = m_tag_reg;
        m_last_next   = m_last_reg;
        m_cnt_next    = m_cnt_reg;

        if (exec) begin
            m_seq_next  = 32'd0;
            m_tag_next  = 32'd0;
            m_last_next = 1'b1;
            m_cnt_next  = compl_reg;
            case (cmd.op)
                OP_ADD: begin
                    m_valid_next = 1'b1;
                    if (outstanding >= 32'(WINDOW)) begin
                        m_status_next = ST_FULL;
                    end else begin
                        tag_we            = 1'b1;
                        ip_next[s_slot]   = 1'b1;
                        held_next[s_slot] = 1'b0;
                        if (qcnt_reg == '0) begin
                            head_next = s_slot;
                        end else begin
                            nlink_next[tail_reg] = s_slot;
                            plink_next[s_slot]   = tail_reg;
                        end
                        tail_next     = s_slot;
                        qcnt_next     = qcnt_reg + CNT_W'(1);
                        m_status_next = ST_ASSIGNED;
                        m_seq_next    = next_seq_reg;
                        next_seq_next = next_seq_reg + 32'd1;
                    end
                end
                OP_REASSIGN: begin
                    m_valid_next = 1'b1;
                    if (qcnt_reg == '0) begin
                        m_status_next = ST_NONE;
                    end else begin
                        // Move the head to the back: unlink it, then append it.
                        if (qcnt_reg > CNT_W'(1)) begin
                            head_next            = n_slot;
                            plink_next[n_slot]   = p_slot;
                            nlink_next[tail_reg] = h_slot;
                            plink_next[h_slot]   = tail_reg;
                            tail_next            = h_slot;
                        end
                        m_status_next = ST_REASSIGNED;
                        m_seq_next    = oldest_reg +
                                        32'(slot_sub(h_slot, oslot_reg));
                        m_tag_next    = tag_reg[h_slot];
                    end
                end
                OP_DONE: begin
                    if (seq_dist >= outstanding) begin
                        m_valid_next = 1'b1;
                        if (back_dist >= 32'd1 && back_dist <= 32'h8000_0000) begin
                            m_status_next = ST_DUPLICATE;
                        end else begin
                            m_status_next = ST_UNKNOWN;
                        end
                    end else if (held_reg[s_slot]) begin
                        m_valid_next  = 1'b1;
                        m_status_next = ST_DUPLICATE;
                    end else if (!ip_reg[s_slot]) begin
                        m_valid_next  = 1'b1;
                        m_status_next = ST_UNKNOWN;
                    end else begin
                        // Take the slot off the in-progress list.
                        if (s_slot == head_reg) begin
                            head_next = n_slot;
                        end else begin
                            nlink_next[p_slot] = n_slot;
                        end
                        if (s_slot == tail_reg) begin
                            tail_next = p_slot;
                        end else begin
                            plink_next[n_slot] = p_slot;
                        end
                        if (qcnt_reg != '0) begin
                            qcnt_next = qcnt_reg - CNT_W'(1);
                        end
                        ip_next[s_slot] = 1'b0;
                        compl_next      = compl_reg + 32'd1;
                        if (seq_dist != 32'd0) begin
                            held_next[s_slot] = 1'b1;
                            m_valid_next      = 1'b1;
                            m_status_next     = ST_HELD;
                            m_seq_next        = cmd.seq;
                            m_cnt_next        = compl_reg + 32'd1;
                        end else begin
                            k_next = '0;
                        end
                    end
                end
                default: begin
                    m_valid_next = m_valid_reg && !m_ready;
                end
            endcase
        end

        // One released word per step, oldest first.
        if (step) begin
            held_next[oslot_reg] = 1'b0;
            oldest_next          = oldest_reg + 32'd1;
            oslot_next           = nx_slot;
            k_next               = k_reg + CNT_W'(1);
            m_valid_next         = 1'b1;
            m_status_next        = ST_RELEASED;
            m_seq_next           = oldest_reg;
            m_tag_next           = 32'd0;
            m_last_next          = !more;
            m_cnt_next           = compl_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BK_IDLE;
            next_seq_reg <= '0;
            oldest_reg   <= '0;
            oslot_reg    <= '0;
            compl_reg    <= '0;
            ip_reg       <= '0;
            held_reg     <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            qcnt_reg     <= '0;
            k_reg        <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            next_seq_reg <= next_seq_next;
            oldest_reg   <= oldest_next;
            oslot_reg    <= oslot_next;
            compl_reg    <= compl_next;
            ip_reg       <= ip_next;
            held_reg     <= held_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            qcnt_reg     <= qcnt_next;
            k_reg        <= k_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Link and tag storage and result payload carry no reset.
    always_ff @(posedge aclk) begin
        nlink_reg    <= nlink_next;
        plink_reg    <= plink_next;
        m_status_reg <= m_status_next;
        m_seq_reg    <= m_seq_next;
        m_tag_reg    <= m_tag_next;
        m_last_reg   <= m_last_next;
        m_cnt_reg    <= m_cnt_next;
        if (tag_we) begin
            tag_reg[tag_addr] <= cmd.tag;
        end
    end

    // The in-progress list length equals the number of slots marked in progress.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(ip_reg) == 32'(qcnt_reg))
        else $error("queue count disagrees with in-progress slots");

    // A slot is never both held and in progress.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ip_reg & held_reg) == '0)
        else $error("slot both held and in progress");

    // A release run only walks over outstanding numbers.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BK_RELEASE |-> oldest_reg != next_seq_reg)
        else $error("release run beyond issued numbers");

    // No new command is taken while a release run is in flight.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BK_RELEASE |-> !cmd_ready)
        else $error("command taken during release run");

endmodule

// ===== rtl/work_item_reorder_tracker.sv =====
// Reorder tracker for dispatched work items over a window of 32 sequence numbers.
// Each accepted word of op 0 (add), op 2 (reassign) or op 1 (done) that does not
// release anything produces one result word in the cycle after it leaves a two-word
// input queue; op 3 produces nothing. A done for the oldest outstanding number
// starts a release run of n numbers, at one result word per cycle while the result
// register is free (n at most 32, last set on the final word); the back end takes
// no new command until the run ends. The two-word input queue lets the input side keep
// accepting while a finished word waits in the result register for m_ready.
module work_item_reorder_tracker import wirt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [31:0] s_seq,
    input  logic [31:0] s_item_tag,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [31:0] m_out_seq,
    output logic [31:0] m_out_tag,
    output logic        m_last,
    output logic [31:0] m_done_count
);

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    // Front end: accept and queue commands.
    wirt_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_op       (s_op),
        .s_seq      (s_seq),
        .s_item_tag (s_item_tag),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd)
    );

    // Back end: window state, in-progress list and release runs.
    wirt_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_out_seq    (m_out_seq),
        .m_out_tag    (m_out_tag),
        .m_last       (m_last),
        .m_done_count (m_done_count)
    );

endmodule
